[rtl/jet_pkg.sv]
package jet_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_BITS  = 28;
    localparam int COORD_W    = 32;
    localparam int CONST_W    = 31;
    localparam int LIMIT_W    = 10;
    localparam int IDX_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Image size; both are powers of two, so the mapping divide is a shift
    localparam int IMAGE_WIDTH  = 1024;
    localparam int IMAGE_HEIGHT = 1024;
    localparam int WIDTH_SHIFT  = $clog2(IMAGE_WIDTH);
    localparam int HEIGHT_SHIFT = $clog2(IMAGE_HEIGHT);

    // Datapath widths
    localparam int SPAN_W = COORD_W + 1;              // window span, exact
    localparam int PROD_W = SPAN_W + IDX_W + 1;       // span * pixel index
    localparam int SAT_W  = PROD_W + 1;               // wide sums before saturation
    localparam int MUL_W  = 2 * COORD_W;              // full product
    localparam int MAG_W  = MUL_W - FRAC_BITS;        // squared term after scaling
    localparam int XY_W   = MUL_W - FRAC_BITS + 1;    // doubled cross term

    // Escape threshold |z|^2 > 4.0
    localparam logic [MAG_W:0] ESCAPE_BOUND = (MAG_W + 1)'(4) << FRAC_BITS;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C_RE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C_IM  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd6;

    // Register reset values
    localparam logic signed [COORD_W-1:0] X_MIN_RESET = -32'sd536870912;
    localparam logic signed [COORD_W-1:0] X_MAX_RESET = 32'sd536870912;
    localparam logic signed [COORD_W-1:0] Y_MIN_RESET = -32'sd402653184;
    localparam logic signed [COORD_W-1:0] Y_MAX_RESET = 32'sd402653184;
    localparam logic signed [CONST_W-1:0] C_RE_RESET  = '0;
    localparam logic signed [CONST_W-1:0] C_IM_RESET  = '0;
    localparam logic [LIMIT_W-1:0]        LIMIT_RESET = 10'd256;

    // One beat travelling down the mapping chain
    typedef struct packed {
        logic signed [PROD_W-1:0] acc_x;
        logic signed [PROD_W-1:0] acc_y;
        logic signed [PROD_W-1:0] span_x;
        logic signed [PROD_W-1:0] span_y;
        logic [IDX_W-1:0]         col;
        logic [IDX_W-1:0]         row;
    } map_beat_t;

    // Settings seen by the iteration engine
    typedef struct packed {
        logic signed [COORD_W-1:0] x_min;
        logic signed [COORD_W-1:0] y_min;
        logic signed [CONST_W-1:0] c_re;
        logic signed [CONST_W-1:0] c_im;
        logic [LIMIT_W-1:0]        limit;
    } iter_cfg_t;

    // Finished pixel offered by the iteration engine
    typedef struct packed {
        logic               valid;
        logic [LIMIT_W-1:0] count;
    } iter_res_t;

    // Clamp a wide signed value to the 32-bit coordinate range
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [SAT_W-1:0] v
    );
        logic fits;
        logic signed [COORD_W-1:0] r;
        fits = (&v[SAT_W-1:COORD_W-1]) | ~(|v[SAT_W-1:COORD_W-1]);
        if (fits)
        begin
            r = v[COORD_W-1:0];
        end
        else if (v[SAT_W-1])
        begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

[rtl/julia_escape_time.sv]
// Channel | Dir | Handshake                  | Payload
// in      | in  | in_valid / in_ready        | pixel_col, pixel_row
// out     | out | out_valid / out_ready      | escape_count
// cfg     | in  | cfg_write_en (no stall)    | cfg_index, cfg_data
//
// A pixel passes through the mapping chain, then the engine runs each
// iteration as a product state followed by a scale/test/update state, with
// load and hand-off around the loop.
// One pixel is in flight at a time; the next is accepted once the result
// sits in the output register, even while out_ready is low.
// Reset (rst_n low, asynchronous) empties the block and restores all
// settings to their defaults.
module julia_escape_time (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [jet_pkg::IDX_W-1:0]          pixel_col,
    input  logic [jet_pkg::IDX_W-1:0]          pixel_row,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [jet_pkg::LIMIT_W-1:0]        escape_count,
    input  logic                               cfg_write_en,
    input  logic [jet_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jet_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic signed [jet_pkg::COORD_W-1:0] x_min_reg;
    logic signed [jet_pkg::COORD_W-1:0] x_max_reg;
    logic signed [jet_pkg::COORD_W-1:0] y_min_reg;
    logic signed [jet_pkg::COORD_W-1:0] y_max_reg;
    logic signed [jet_pkg::CONST_W-1:0] c_re_reg;
    logic signed [jet_pkg::CONST_W-1:0] c_im_reg;
    logic [jet_pkg::LIMIT_W-1:0]        limit_reg;

    logic busy_reg;
    logic busy_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic [jet_pkg::LIMIT_W-1:0] escape_count_reg;

    logic in_take;
    logic res_take;
    logic signed [jet_pkg::SPAN_W-1:0] span_x;
    logic signed [jet_pkg::SPAN_W-1:0] span_y;
    jet_pkg::map_beat_t seed_beat;

    logic               chain_valid [0:jet_pkg::IDX_W];
    jet_pkg::map_beat_t chain_beat  [0:jet_pkg::IDX_W];

    jet_pkg::iter_cfg_t iter_cfg;
    jet_pkg::iter_res_t iter_res;

    // Write settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg <= jet_pkg::X_MIN_RESET;
            x_max_reg <= jet_pkg::X_MAX_RESET;
            y_min_reg <= jet_pkg::Y_MIN_RESET;
            y_max_reg <= jet_pkg::Y_MAX_RESET;
            c_re_reg  <= jet_pkg::C_RE_RESET;
            c_im_reg  <= jet_pkg::C_IM_RESET;
            limit_reg <= jet_pkg::LIMIT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                jet_pkg::REG_X_MIN: x_min_reg <= cfg_data;
                jet_pkg::REG_X_MAX: x_max_reg <= cfg_data;
                jet_pkg::REG_Y_MIN: y_min_reg <= cfg_data;
                jet_pkg::REG_Y_MAX: y_max_reg <= cfg_data;
                jet_pkg::REG_C_RE:  c_re_reg  <= cfg_data[jet_pkg::CONST_W-1:0];
                jet_pkg::REG_C_IM:  c_im_reg  <= cfg_data[jet_pkg::CONST_W-1:0];
                jet_pkg::REG_LIMIT: limit_reg <= cfg_data[jet_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Accept a pixel beat only when nothing is in flight
    assign in_ready = !busy_reg;
    assign in_take  = in_valid && !busy_reg;
    assign res_take = iter_res.valid && (!out_valid_reg || out_ready);

    // Seed the mapping chain with the window spans
    always_comb
    begin
        span_x = jet_pkg::SPAN_W'(x_max_reg) - jet_pkg::SPAN_W'(x_min_reg);
        span_y = jet_pkg::SPAN_W'(y_max_reg) - jet_pkg::SPAN_W'(y_min_reg);
        seed_beat.acc_x  = '0;
        seed_beat.acc_y  = '0;
        seed_beat.span_x = jet_pkg::PROD_W'(span_x);
        seed_beat.span_y = jet_pkg::PROD_W'(span_y);
        seed_beat.col    = pixel_col;
        seed_beat.row    = pixel_row;
    end

    assign chain_valid[0] = in_take;
    assign chain_beat[0]  = seed_beat;

    // One cell per pixel index bit
    for (genvar k = 0; k < jet_pkg::IDX_W; k++)
    begin : g_cell
        jet_map_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_beat   (chain_beat[k]),
            .out_valid (chain_valid[k+1]),
            .out_beat  (chain_beat[k+1])
        );
    end

    always_comb
    begin
        iter_cfg.x_min = x_min_reg;
        iter_cfg.y_min = y_min_reg;
        iter_cfg.c_re  = c_re_reg;
        iter_cfg.c_im  = c_im_reg;
        iter_cfg.limit = limit_reg;
    end

    jet_iter u_iter (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (iter_cfg),
        .map_valid (chain_valid[jet_pkg::IDX_W]),
        .map_beat  (chain_beat[jet_pkg::IDX_W]),
        .res       (iter_res),
        .res_take  (res_take)
    );

    // Track the pixel in flight and the output slot
    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_take)
        begin
            out_valid_next = 1'b1;
            busy_next      = 1'b0;
        end
        if (in_take)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            escape_count_reg <= iter_res.count;
        end
    end

    assign out_valid    = out_valid_reg;
    assign escape_count = escape_count_reg;

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second pixel accepted while one is in flight");

    a_chain_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_valid[jet_pkg::IDX_W] || iter_res.valid) |-> busy_reg)
        else $error("pixel work without an accepted beat");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> out_valid && in_ready)
        else $error("result not moved into the output register");

endmodule

[rtl/jet_map_cell.sv]
// One cell of the coordinate mapping chain: consumes the low bit of each
// pixel index, adds the matching span multiple, and hands the beat on.
module jet_map_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  jet_pkg::map_beat_t in_beat,
    output logic               out_valid,
    output jet_pkg::map_beat_t out_beat
);

    logic               valid_reg;
    jet_pkg::map_beat_t beat_reg;
    jet_pkg::map_beat_t beat_next;

    // Add span when the index bit is set, then shift span up and index down
    always_comb
    begin
        beat_next        = in_beat;
        beat_next.acc_x  = in_beat.acc_x + (in_beat.col[0] ? in_beat.span_x : '0);
        beat_next.acc_y  = in_beat.acc_y + (in_beat.row[0] ? in_beat.span_y : '0);
        beat_next.span_x = in_beat.span_x <<< 1;
        beat_next.span_y = in_beat.span_y <<< 1;
        beat_next.col    = in_beat.col >> 1;
        beat_next.row    = in_beat.row >> 1;
    end

    // Hold the valid flag under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Advance the payload every cycle
    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

[rtl/jet_iter.sv]
// Escape-time engine: loads the mapped point, then loops z = z*z + c with a
// multiply state and an update/test state per iteration.
module jet_iter (
    input  logic                clk,
    input  logic                rst_n,
    input  jet_pkg::iter_cfg_t  cfg,
    input  logic                map_valid,
    input  jet_pkg::map_beat_t  map_beat,
    output jet_pkg::iter_res_t  res,
    input  logic                res_take
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_TEST = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [jet_pkg::LIMIT_W-1:0] cnt_reg;
    logic [jet_pkg::LIMIT_W-1:0] cnt_next;
    logic [jet_pkg::LIMIT_W-1:0] res_count_reg;
    logic [jet_pkg::LIMIT_W-1:0] res_count_next;
    logic signed [jet_pkg::COORD_W-1:0] x_reg;
    logic signed [jet_pkg::COORD_W-1:0] x_next;
    logic signed [jet_pkg::COORD_W-1:0] y_reg;
    logic signed [jet_pkg::COORD_W-1:0] y_next;
    logic signed [jet_pkg::MUL_W-1:0] xx_reg;
    logic signed [jet_pkg::MUL_W-1:0] yy_reg;
    logic signed [jet_pkg::MUL_W-1:0] xy_reg;
    logic signed [jet_pkg::MUL_W-1:0] xx_next;
    logic signed [jet_pkg::MUL_W-1:0] yy_next;
    logic signed [jet_pkg::MUL_W-1:0] xy_next;

    logic signed [jet_pkg::PROD_W-1:0] acc_x;
    logic signed [jet_pkg::PROD_W-1:0] acc_y;
    logic signed [jet_pkg::COORD_W-1:0] x_load;
    logic signed [jet_pkg::COORD_W-1:0] y_load;
    logic signed [jet_pkg::MAG_W-1:0] x2;
    logic signed [jet_pkg::MAG_W-1:0] y2;
    logic [jet_pkg::MAG_W:0] mag;
    logic signed [jet_pkg::XY_W-1:0] xy2;
    logic escape;
    logic signed [jet_pkg::COORD_W-1:0] x_upd;
    logic signed [jet_pkg::COORD_W-1:0] y_upd;

    // Finish the mapping: scale the chain product down and add the window edge
    always_comb
    begin
        acc_x  = map_beat.acc_x;
        acc_y  = map_beat.acc_y;
        x_load = jet_pkg::sat_coord(jet_pkg::SAT_W'(cfg.x_min)
                                    + jet_pkg::SAT_W'(acc_x >>> jet_pkg::WIDTH_SHIFT));
        y_load = jet_pkg::sat_coord(jet_pkg::SAT_W'(cfg.y_min)
                                    + jet_pkg::SAT_W'(acc_y >>> jet_pkg::HEIGHT_SHIFT));
    end

    // Form the three products of the current point
    assign xx_next = x_reg * x_reg;
    assign yy_next = y_reg * y_reg;
    assign xy_next = x_reg * y_reg;

    // Scale products, test the escape radius, build the next point
    always_comb
    begin
        x2     = xx_reg[jet_pkg::MUL_W-1:jet_pkg::FRAC_BITS];
        y2     = yy_reg[jet_pkg::MUL_W-1:jet_pkg::FRAC_BITS];
        mag    = {1'b0, x2} + {1'b0, y2};
        escape = mag > jet_pkg::ESCAPE_BOUND;
        xy2    = xy_reg[jet_pkg::MUL_W-1:jet_pkg::FRAC_BITS-1];
        x_upd  = jet_pkg::sat_coord(jet_pkg::SAT_W'(x2) - jet_pkg::SAT_W'(y2)
                                    + jet_pkg::SAT_W'(cfg.c_re));
        y_upd  = jet_pkg::sat_coord(jet_pkg::SAT_W'(xy2) + jet_pkg::SAT_W'(cfg.c_im));
    end

    // Sequence load, multiply, update and hand-off
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        res_count_next = res_count_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (map_valid)
                begin
                    x_next     = x_load;
                    y_next     = y_load;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == cfg.limit)
                begin
                    res_count_next = '0;
                    state_next     = ST_DONE;
                end
                else
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (escape)
                begin
                    res_count_next = cnt_reg;
                    state_next     = ST_DONE;
                end
                else
                begin
                    x_next     = x_upd;
                    y_next     = y_upd;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        xx_reg        <= xx_next;
        yy_reg        <= yy_next;
        xy_reg        <= xy_next;
        res_count_reg <= res_count_next;
    end

    assign res.valid = (state_reg == ST_DONE);
    assign res.count = res_count_reg;

    a_limit_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && cnt_reg == cfg.limit) |=> res.valid && res.count == '0)
        else $error("limit reached without a zero result");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEST && !escape) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("iteration count did not advance");

endmodule

[tb/sv/julia_escape_time_tb.sv]
module julia_escape_time_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Escape bound |z|^2 > 4.0 and the spread of the "interesting" constants
    localparam longint BAILOUT = 64'sd1 <<< 30;
    localparam int C_NEAR = 228170138;
    localparam logic [jet_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // Settings the predictor works from
    typedef struct {
        logic signed [jet_pkg::COORD_W-1:0] x_lo;
        logic signed [jet_pkg::COORD_W-1:0] x_hi;
        logic signed [jet_pkg::COORD_W-1:0] y_lo;
        logic signed [jet_pkg::COORD_W-1:0] y_hi;
        logic signed [jet_pkg::CONST_W-1:0] c_re;
        logic signed [jet_pkg::CONST_W-1:0] c_im;
        logic [jet_pkg::LIMIT_W-1:0]        limit;
    } plane_view_t;

    typedef struct {
        logic [jet_pkg::IDX_W-1:0]   col;
        logic [jet_pkg::IDX_W-1:0]   row;
        logic [jet_pkg::LIMIT_W-1:0] count;
    } pixel_check_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [jet_pkg::IDX_W-1:0]      pixel_col = '0;
    logic [jet_pkg::IDX_W-1:0]      pixel_row = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [jet_pkg::LIMIT_W-1:0]    escape_count;
    logic                           cfg_write_en = 1'b0;
    logic [jet_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [jet_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    plane_view_t  cur_view;
    pixel_check_t awaited_counts[$];
    int           mismatches = 0;
    bit           idle_on = 1'b1;

    julia_escape_time uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel_col    (pixel_col),
        .pixel_row    (pixel_row),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .escape_count (escape_count),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Clamp to the signed 32-bit coordinate range
    function automatic logic signed [jet_pkg::COORD_W-1:0] clamp_q428(longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fff_ffff;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[jet_pkg::COORD_W-1:0];
    endfunction

    // Linear map of a pixel index into [lo, hi), floor on the divide
    function automatic longint map_axis(logic signed [jet_pkg::COORD_W-1:0] lo,
                                        logic signed [jet_pkg::COORD_W-1:0] hi,
                                        logic [jet_pkg::IDX_W-1:0] idx, int shift);
        longint span;
        longint off;
        span = longint'(hi) - longint'(lo);
        off = (span * longint'(idx)) >>> shift;
        return longint'(clamp_q428(longint'(lo) + off));
    endfunction

    // Iterate z = z*z + c and return the escape count, 0 when the limit is hit
    function automatic logic [jet_pkg::LIMIT_W-1:0] escape_time(
        plane_view_t v,
        logic [jet_pkg::IDX_W-1:0] col,
        logic [jet_pkg::IDX_W-1:0] row
    );
        longint x;
        longint y;
        longint x2;
        longint y2;
        longint xy2;
        int     n;
        bit     escaped;
        x = map_axis(v.x_lo, v.x_hi, col, jet_pkg::WIDTH_SHIFT);
        y = map_axis(v.y_lo, v.y_hi, row, jet_pkg::HEIGHT_SHIFT);
        n = 0;
        escaped = 1'b0;
        while (!escaped && n < int'(v.limit))
        begin
            x2 = (x * x) >>> jet_pkg::FRAC_BITS;
            y2 = (y * y) >>> jet_pkg::FRAC_BITS;
            if (x2 + y2 > BAILOUT)
            begin
                escaped = 1'b1;
            end
            else
            begin
                xy2 = (x * y) >>> (jet_pkg::FRAC_BITS - 1);
                y = longint'(clamp_q428(xy2 + longint'(v.c_im)));
                x = longint'(clamp_q428(x2 - y2 + longint'(v.c_re)));
                n++;
            end
        end
        return escaped ? jet_pkg::LIMIT_W'(n) : '0;
    endfunction

    // Mostly short gaps, a few long ones, none while idling is off
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 50)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic plane_view_t random_view(bit noise);
        plane_view_t                        v;
        longint                             cx;
        longint                             cy;
        longint                             hw;
        longint                             hh;
        logic signed [jet_pkg::COORD_W-1:0] t;
        if (noise)
        begin
            v.x_lo = $urandom();
            v.x_hi = $urandom();
            v.y_lo = $urandom();
            v.y_hi = $urandom();
            v.c_re = jet_pkg::CONST_W'($urandom());
            v.c_im = jet_pkg::CONST_W'($urandom());
            v.limit = jet_pkg::LIMIT_W'($urandom_range(0, 40));
        end
        else
        begin
            // window around a random center, zoom spread over several octaves
            cx = longint'($urandom_range(0, 1 << 29)) - (64'sd1 <<< 28);
            cy = longint'($urandom_range(0, 1 << 29)) - (64'sd1 <<< 28);
            hw = (64'sd1 <<< $urandom_range(18, 29)) + longint'($urandom_range(0, 1 << 18));
            hh = (hw * longint'($urandom_range(2, 4))) / 4;
            v.x_lo = jet_pkg::COORD_W'(cx - hw);
            v.x_hi = jet_pkg::COORD_W'(cx + hw);
            v.y_lo = jet_pkg::COORD_W'(cy - hh);
            v.y_hi = jet_pkg::COORD_W'(cy + hh);
            if ($urandom_range(0, 7) == 0)
            begin
                t = v.x_lo;
                v.x_lo = v.x_hi;
                v.x_hi = t;
            end
            if ($urandom_range(0, 7) == 0)
            begin
                t = v.y_lo;
                v.y_lo = v.y_hi;
                v.y_hi = t;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                v.c_re = jet_pkg::CONST_W'(longint'($urandom_range(0, 2 * C_NEAR)) - C_NEAR);
                v.c_im = jet_pkg::CONST_W'(longint'($urandom_range(0, 2 * C_NEAR)) - C_NEAR);
            end
            else
            begin
                v.c_re = jet_pkg::CONST_W'(longint'($urandom_range(0, 1 << 30))
                                           - (64'sd1 <<< 29));
                v.c_im = jet_pkg::CONST_W'(longint'($urandom_range(0, 1 << 30))
                                           - (64'sd1 <<< 29));
            end
            if ($urandom_range(0, 4) == 0)
            begin
                v.limit = jet_pkg::LIMIT_W'($urandom_range(41, 200));
            end
            else
            begin
                v.limit = jet_pkg::LIMIT_W'($urandom_range(1, 40));
            end
        end
        return v;
    endfunction

    task automatic put_reg(logic [jet_pkg::CFG_IDX_W-1:0] idx,
                           logic [jet_pkg::CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Write every register; unused bits of the narrow ones get random filler
    task automatic apply_view(plane_view_t v, bit stray);
        put_reg(jet_pkg::REG_X_MIN, v.x_lo);
        put_reg(jet_pkg::REG_X_MAX, v.x_hi);
        put_reg(jet_pkg::REG_Y_MIN, v.y_lo);
        put_reg(jet_pkg::REG_Y_MAX, v.y_hi);
        put_reg(jet_pkg::REG_C_RE, {1'($urandom()), v.c_re});
        put_reg(jet_pkg::REG_C_IM, {1'($urandom()), v.c_im});
        put_reg(jet_pkg::REG_LIMIT, {22'($urandom()), v.limit});
        if (stray)
        begin
            put_reg(REG_UNUSED, $urandom());
        end
        cfg_write_en <= 1'b0;
        cur_view = v;
    endtask

    // Offer one pixel beat and record its expected count once accepted
    task automatic send_pixel(logic [jet_pkg::IDX_W-1:0] col,
                              logic [jet_pkg::IDX_W-1:0] row);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_col <= col;
        pixel_row <= row;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        awaited_counts.push_back('{col, row, escape_time(cur_view, col, row)});
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (awaited_counts.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    task automatic test_default_view();
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd341, 10'd682);
        drain_results();
    endtask

    task automatic test_extreme_settings();
        plane_view_t v;
        // full-range window, reversed in y, extreme constants, zero limit
        v = cur_view;
        v.x_lo = 32'sh8000_0000;
        v.x_hi = 32'sh7fff_ffff;
        v.y_lo = 32'sh7fff_ffff;
        v.y_hi = 32'sh8000_0000;
        v.c_re = 31'sh4000_0000;
        v.c_im = 31'sh3fff_ffff;
        v.limit = '0;
        apply_view(v, 1'b0);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd512, 10'd512);
        drain_results();

        // same window, single iteration
        v.limit = 10'd1;
        apply_view(v, 1'b0);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd512, 10'd512);
        drain_results();

        // tiny window at the origin, constant far out: escapes after one step
        v.x_lo = -32'sd1;
        v.x_hi = 32'sd1;
        v.y_lo = -32'sd1;
        v.y_hi = 32'sd1;
        v.c_re = 31'sh3fff_ffff;
        v.c_im = 31'sh4000_0000;
        v.limit = 10'd1023;
        apply_view(v, 1'b0);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        drain_results();

        // c = -2 on the real axis: orbit sits exactly on |z|^2 = 4
        v.x_lo = jet_pkg::X_MIN_RESET;
        v.x_hi = jet_pkg::X_MAX_RESET;
        v.y_lo = jet_pkg::Y_MIN_RESET;
        v.y_hi = jet_pkg::Y_MAX_RESET;
        v.c_re = -31'sd536870912;
        v.c_im = '0;
        apply_view(v, 1'b0);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd768, 10'd512);
        send_pixel(10'd0, 10'd0);
        drain_results();

        // positive constants, c = 2.0 + 2.0i
        v.c_re = 31'sd536870912;
        v.c_im = 31'sd536870912;
        apply_view(v, 1'b0);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd100, 10'd900);
        drain_results();

        // write to the unused index must leave every setting alone
        put_reg(REG_UNUSED, 32'hffff_ffff);
        cfg_write_en <= 1'b0;
        send_pixel(10'd512, 10'd512);
        drain_results();
    endtask

    task automatic test_random_views();
        int          sent;
        int          burst;
        bit          noise;
        plane_view_t v;
        sent = 0;
        while (sent < 1600)
        begin
            noise = ($urandom_range(0, 4) == 0);
            idle_on = ($urandom_range(0, 3) != 0);
            v = random_view(noise);
            apply_view(v, $urandom_range(0, 5) == 0);
            burst = noise ? 40 : $urandom_range(60, 140);
            repeat (burst)
            begin
                send_pixel(jet_pkg::IDX_W'($urandom()), jet_pkg::IDX_W'($urandom()));
            end
            sent += burst;
            drain_results();
        end
        idle_on = 1'b1;
    endtask

    // Rabbit constant at the full limit: long orbits that stay bounded
    task automatic test_deep_orbits();
        plane_view_t v;
        v.x_lo = -32'sd402653184;
        v.x_hi = 32'sd402653184;
        v.y_lo = -32'sd402653184;
        v.y_hi = 32'sd402653184;
        v.c_re = -31'sd32899450;
        v.c_im = 31'sd199946834;
        v.limit = 10'd1023;
        apply_view(v, 1'b0);
        repeat (20)
        begin
            send_pixel(jet_pkg::IDX_W'($urandom_range(400, 624)),
                       jet_pkg::IDX_W'($urandom_range(400, 624)));
        end
        drain_results();
    endtask

    // Receiver stalls
    initial
    begin
        int n;
        forever
        begin
            n = pick_gap();
            if (n != 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Compare each result beat with the oldest expected count
    always @(posedge clk)
    begin : check_counts
        pixel_check_t head;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_counts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected escape_count %0d with nothing outstanding",
                             escape_count);
                end
            end
            else
            begin
                head = awaited_counts.pop_front();
                if (escape_count !== head.count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("escape_count at pixel (%0d,%0d): expected %0d, got %0d",
                                 head.col, head.row, head.count, escape_count);
                    end
                end
            end
        end
    end

    initial
    begin
        cur_view = '{jet_pkg::X_MIN_RESET, jet_pkg::X_MAX_RESET,
                     jet_pkg::Y_MIN_RESET, jet_pkg::Y_MAX_RESET,
                     jet_pkg::C_RE_RESET, jet_pkg::C_IM_RESET,
                     jet_pkg::LIMIT_RESET};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_view();
        test_extreme_settings();
        test_random_views();
        test_deep_orbits();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && awaited_counts.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/jet_pkg.sv
rtl/jet_map_cell.sv
rtl/jet_iter.sv
rtl/julia_escape_time.sv
tb/sv/julia_escape_time_tb.sv
